@@ src/spi_nor_flash_command_sequencer_defines.svh @@
// Assertion macros shared by the flash command sequencer modules
`ifndef SPI_NOR_FLASH_COMMAND_SEQUENCER_DEFINES_SVH
`define SPI_NOR_FLASH_COMMAND_SEQUENCER_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define SNFCS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked out of reset
`define SNFCS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/snfcs_pkg.sv @@
// Shared constants and types of the flash command sequencer
package snfcs_pkg;

   localparam int PAGE_BYTES   = 256;
   localparam int SECTOR_BYTES = 4096;
   localparam int ADDR_BITS    = 24;

   localparam int FRAME_ADDR_W = 24;
   localparam int LEN_W        = 16;
   localparam int PAGE_W       = $clog2(PAGE_BYTES);
   localparam int SECTOR_W     = $clog2(SECTOR_BYTES);
   localparam int CHUNK_W      = PAGE_W + 1;

   localparam int MAX_RESULTS  = 8;
   localparam int IDX_W        = $clog2(MAX_RESULTS);
   localparam int CNT_W        = IDX_W + 1;

   localparam logic [2:0] REQ_BEGIN_READ  = 3'd0;
   localparam logic [2:0] REQ_BEGIN_WRITE = 3'd1;
   localparam logic [2:0] REQ_WRITE_DATA  = 3'd2;
   localparam logic [2:0] REQ_READ_SLOT   = 3'd3;
   localparam logic [2:0] REQ_STATUS      = 3'd4;
   localparam logic [2:0] REQ_INIT        = 3'd5;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       frame_start;
      logic       frame_end;
      logic       read_slot;
      logic       status_slot;
   } result_type;

   // All transfers caused by one request
   typedef struct packed {
      logic [CNT_W-1:0]                   count;
      logic                               wp;
      result_type [MAX_RESULTS-1:0]       item;
   } burst_type;

endpackage

@@ src/snfcs_core.sv @@
// Request register, sequencer state and transfer list generation
`include "spi_nor_flash_command_sequencer_defines.svh"

module snfcs_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [2:0]           req_type,
   input  logic [23:0]          req_address,
   input  logic [15:0]          req_length,
   input  logic [7:0]           req_data_byte,
   input  logic [7:0]           req_status_byte,
   input  logic                 buf_ready,
   output logic                 push,
   output snfcs_pkg::burst_type burst
);
   import snfcs_pkg::*;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_READ = 2'd1;
   localparam logic [1:0] PH_DATA = 2'd2;
   localparam logic [1:0] PH_POLL = 2'd3;

   localparam logic [2:0] RS_IDLE       = 3'd0;
   localparam logic [2:0] RS_ERASE_EWSR = 3'd1;
   localparam logic [2:0] RS_ERASE_CMD  = 3'd2;
   localparam logic [2:0] RS_ERASE_WD   = 3'd3;
   localparam logic [2:0] RS_PRE        = 3'd4;
   localparam logic [2:0] RS_PAGE_EWSR  = 3'd5;
   localparam logic [2:0] RS_FINAL      = 3'd6;
   localparam logic [2:0] RS_FINAL_WD   = 3'd7;

   localparam logic [7:0] OP_WRSR   = 8'h01;
   localparam logic [7:0] OP_PP     = 8'h02;
   localparam logic [7:0] OP_READ   = 8'h03;
   localparam logic [7:0] OP_WRDI   = 8'h04;
   localparam logic [7:0] OP_RDSR   = 8'h05;
   localparam logic [7:0] OP_WREN   = 8'h06;
   localparam logic [7:0] OP_SE     = 8'h20;
   localparam logic [7:0] OP_EWSR   = 8'h50;
   localparam logic [7:0] OP_INIT   = 8'hE9;
   localparam logic [7:0] FILL_BYTE = 8'h00;

   // request register
   logic                 in_valid_ff;
   logic [2:0]           type_ff;
   logic [ADDR_BITS-1:0] in_addr_ff;
   logic [LEN_W-1:0]     len_ff;
   logic [7:0]           data_ff;
   logic [7:0]           stat_ff;

   // sequencer state
   logic [1:0]           phase_ff,  phase_in;
   logic [2:0]           resume_ff, resume_in;
   logic [ADDR_BITS-1:0] addr_ff,   addr_in;
   logic [LEN_W-1:0]     left_ff,   left_in;
   logic [CHUNK_W-1:0]   chunk_ff,  chunk_in;
   logic                 wp_ff,     wp_in;

   logic                 step;
   logic [ADDR_BITS-1:0] addr_inc;
   logic [LEN_W-1:0]     left_dec;
   logic [CHUNK_W-1:0]   chunk_dec;
   logic [ADDR_BITS-1:0] sc_addr;
   logic [LEN_W-1:0]     sc_left;
   logic [CHUNK_W-1:0]   sc_room;
   logic [CHUNK_W-1:0]   sc_chunk;
   logic                 sc_erase;
   burst_type            burst_c;

   function automatic burst_type add_item(input burst_type b, input logic [7:0] tx,
                                          input logic fs, input logic fe,
                                          input logic rd, input logic st);
      burst_type r;
      r = b;
      if (r.count < CNT_W'(MAX_RESULTS)) begin
         r.item[r.count[IDX_W-1:0]] = '{tx_byte: tx, frame_start: fs, frame_end: fe,
                                        read_slot: rd, status_slot: st};
         r.count = r.count + CNT_W'(1);
      end
      return r;
   endfunction

   function automatic burst_type add_poll(input burst_type b);
      burst_type r;
      r = add_item(b, OP_RDSR, 1'b1, 1'b0, 1'b0, 1'b0);
      r = add_item(r, FILL_BYTE, 1'b0, 1'b1, 1'b0, 1'b1);
      return r;
   endfunction

   function automatic burst_type add_ewsr(input burst_type b);
      burst_type r;
      r = add_item(b, OP_EWSR, 1'b1, 1'b1, 1'b0, 1'b0);
      r = add_item(r, OP_WRSR, 1'b1, 1'b0, 1'b0, 1'b0);
      r = add_item(r, FILL_BYTE, 1'b0, 1'b1, 1'b0, 1'b0);
      return r;
   endfunction

   function automatic burst_type add_addr(input burst_type b, input logic [ADDR_BITS-1:0] a,
                                          input logic fe);
      burst_type               r;
      logic [FRAME_ADDR_W-1:0] fa;
      fa = FRAME_ADDR_W'(a);
      r = add_item(b, fa[23:16], 1'b0, 1'b0, 1'b0, 1'b0);
      r = add_item(r, fa[15:8], 1'b0, 1'b0, 1'b0, 1'b0);
      r = add_item(r, fa[7:0], 1'b0, fe, 1'b0, 1'b0);
      return r;
   endfunction

   // zero-result requests retire without waiting for the result buffer
   assign step      = in_valid_ff && (burst_c.count == '0 || buf_ready);
   assign req_ready = !in_valid_ff || step;
   assign push      = step && burst_c.count != '0;
   assign burst     = burst_c;

   assign addr_inc  = addr_ff + ADDR_BITS'(1);
   assign left_dec  = left_ff - LEN_W'(1);
   assign chunk_dec = chunk_ff - CHUNK_W'(1);

   // next page chunk: starts a new write or follows the last byte of a chunk
   always_comb begin
      if (type_ff == REQ_BEGIN_WRITE) begin
         sc_addr = in_addr_ff;
         sc_left = len_ff;
      end else begin
         sc_addr = addr_inc;
         sc_left = left_dec;
      end
      sc_room  = CHUNK_W'(PAGE_BYTES) - CHUNK_W'(sc_addr[PAGE_W-1:0]);
      sc_chunk = (sc_left < LEN_W'(sc_room)) ? CHUNK_W'(sc_left) : sc_room;
      sc_erase = sc_addr[SECTOR_W-1:0] == '0;
   end

   always_comb begin
      phase_in  = phase_ff;
      resume_in = resume_ff;
      addr_in   = addr_ff;
      left_in   = left_ff;
      chunk_in  = chunk_ff;
      wp_in     = wp_ff;
      burst_c   = '0;

      unique case (type_ff)
         REQ_BEGIN_READ: begin
            if (phase_ff == PH_IDLE) begin
               burst_c  = add_item(burst_c, OP_READ, 1'b1, 1'b0, 1'b0, 1'b0);
               burst_c  = add_addr(burst_c, in_addr_ff, len_ff == '0);
               left_in  = len_ff;
               phase_in = (len_ff == '0) ? PH_IDLE : PH_READ;
            end
         end
         REQ_BEGIN_WRITE: begin
            if (phase_ff == PH_IDLE) begin
               addr_in = in_addr_ff;
               left_in = len_ff;
               if (len_ff == '0) begin
                  burst_c   = add_poll(burst_c);
                  phase_in  = PH_POLL;
                  resume_in = RS_FINAL;
               end else begin
                  chunk_in = sc_chunk;
                  phase_in = PH_POLL;
                  if (sc_erase) begin
                     burst_c   = add_ewsr(burst_c);
                     burst_c   = add_poll(burst_c);
                     resume_in = RS_ERASE_EWSR;
                  end else begin
                     burst_c   = add_poll(burst_c);
                     resume_in = RS_PRE;
                  end
               end
            end
         end
         REQ_WRITE_DATA: begin
            if (phase_ff == PH_DATA) begin
               chunk_in = chunk_dec;
               left_in  = left_dec;
               addr_in  = addr_inc;
               burst_c  = add_item(burst_c, data_ff, 1'b0, chunk_dec == '0, 1'b0, 1'b0);
               if (chunk_dec == '0) begin
                  phase_in = PH_POLL;
                  if (left_dec == '0) begin
                     burst_c   = add_poll(burst_c);
                     resume_in = RS_FINAL;
                  end else begin
                     chunk_in = sc_chunk;
                     if (sc_erase) begin
                        burst_c   = add_ewsr(burst_c);
                        burst_c   = add_poll(burst_c);
                        resume_in = RS_ERASE_EWSR;
                     end else begin
                        burst_c   = add_poll(burst_c);
                        resume_in = RS_PRE;
                     end
                  end
               end
            end
         end
         REQ_READ_SLOT: begin
            if (phase_ff == PH_READ) begin
               left_in = left_dec;
               burst_c = add_item(burst_c, FILL_BYTE, 1'b0, left_dec == '0, 1'b1, 1'b0);
               if (left_dec == '0) begin
                  phase_in = PH_IDLE;
               end
            end
         end
         REQ_STATUS: begin
            if (phase_ff == PH_POLL) begin
               if (stat_ff[0]) begin
                  // still busy: poll again, same continuation
                  burst_c = add_poll(burst_c);
               end else begin
                  unique case (resume_ff)
                     RS_ERASE_EWSR: begin
                        wp_in     = 1'b1;
                        burst_c   = add_item(burst_c, OP_WREN, 1'b1, 1'b1, 1'b0, 1'b0);
                        burst_c   = add_item(burst_c, OP_SE, 1'b1, 1'b0, 1'b0, 1'b0);
                        burst_c   = add_addr(burst_c, addr_ff, 1'b1);
                        burst_c   = add_poll(burst_c);
                        resume_in = RS_ERASE_CMD;
                     end
                     RS_ERASE_CMD: begin
                        burst_c   = add_item(burst_c, OP_WRDI, 1'b1, 1'b1, 1'b0, 1'b0);
                        burst_c   = add_poll(burst_c);
                        resume_in = RS_ERASE_WD;
                     end
                     RS_ERASE_WD: begin
                        wp_in     = 1'b0;
                        burst_c   = add_poll(burst_c);
                        resume_in = RS_PRE;
                     end
                     RS_PRE: begin
                        burst_c   = add_ewsr(burst_c);
                        burst_c   = add_poll(burst_c);
                        resume_in = RS_PAGE_EWSR;
                     end
                     RS_PAGE_EWSR: begin
                        wp_in     = 1'b1;
                        burst_c   = add_item(burst_c, OP_WREN, 1'b1, 1'b1, 1'b0, 1'b0);
                        burst_c   = add_item(burst_c, OP_PP, 1'b1, 1'b0, 1'b0, 1'b0);
                        burst_c   = add_addr(burst_c, addr_ff, 1'b0);
                        phase_in  = PH_DATA;
                        resume_in = RS_IDLE;
                     end
                     RS_FINAL: begin
                        burst_c   = add_item(burst_c, OP_WRDI, 1'b1, 1'b1, 1'b0, 1'b0);
                        burst_c   = add_poll(burst_c);
                        resume_in = RS_FINAL_WD;
                     end
                     default: begin
                        // end of write: release write protect, no transfer
                        wp_in     = 1'b0;
                        phase_in  = PH_IDLE;
                        resume_in = RS_IDLE;
                     end
                  endcase
               end
            end
         end
         REQ_INIT: begin
            if (phase_ff == PH_IDLE) begin
               wp_in   = 1'b1;
               burst_c = add_item(burst_c, OP_INIT, 1'b1, 1'b1, 1'b0, 1'b0);
            end
         end
         default: begin
         end
      endcase

      burst_c.wp = wp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         type_ff    <= req_type;
         in_addr_ff <= req_address[ADDR_BITS-1:0];
         len_ff     <= req_length;
         data_ff    <= req_data_byte;
         stat_ff    <= req_status_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         resume_ff <= RS_IDLE;
         addr_ff   <= '0;
         left_ff   <= '0;
         chunk_ff  <= '0;
         wp_ff     <= 1'b0;
      end else if (step) begin
         phase_ff  <= phase_in;
         resume_ff <= resume_in;
         addr_ff   <= addr_in;
         left_ff   <= left_in;
         chunk_ff  <= chunk_in;
         wp_ff     <= wp_in;
      end
   end

   `SNFCS_ASSERT_NOW(a_poll_has_target, phase_ff == PH_POLL, resume_ff != RS_IDLE, "poll wait without continuation")
   `SNFCS_ASSERT_NOW(a_data_chunk_open, phase_ff == PH_DATA, chunk_ff != '0 && wp_ff, "data phase with empty chunk or protected")
   `SNFCS_ASSERT_NOW(a_push_fits, push, burst_c.count <= CNT_W'(MAX_RESULTS) && buf_ready, "transfer list pushed into busy buffer")

endmodule

@@ src/snfcs_outbuf.sv @@
// Result buffer that hands out the transfers of one request, one per cycle while rsp_ready is high
`include "spi_nor_flash_command_sequencer_defines.svh"

module snfcs_outbuf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  snfcs_pkg::burst_type burst,
   output logic                 buf_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_tx_byte,
   output logic                 rsp_frame_start,
   output logic                 rsp_frame_end,
   output logic                 rsp_read_slot,
   output logic                 rsp_status_slot,
   output logic                 rsp_wp_pin,
   output logic                 rsp_last
);
   import snfcs_pkg::*;

   burst_type        burst_ff;
   logic [IDX_W-1:0] idx_ff;
   logic             busy_ff;

   result_type       cur;
   logic             is_last;
   logic             taken;
   logic             done;

   assign cur       = burst_ff.item[idx_ff];
   assign is_last   = CNT_W'(idx_ff) == burst_ff.count - CNT_W'(1);
   assign taken     = busy_ff && rsp_ready;
   assign done      = taken && is_last;
   assign buf_ready = !busy_ff || done;

   assign rsp_valid       = busy_ff;
   assign rsp_tx_byte     = cur.tx_byte;
   assign rsp_frame_start = cur.frame_start;
   assign rsp_frame_end   = cur.frame_end;
   assign rsp_read_slot   = cur.read_slot;
   assign rsp_status_slot = cur.status_slot;
   assign rsp_wp_pin      = burst_ff.wp;
   assign rsp_last        = is_last;

   always_ff @(posedge clock) begin
      if (push) begin
         burst_ff <= burst;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else if (push) begin
         busy_ff <= 1'b1;
         idx_ff  <= '0;
      end else if (done) begin
         busy_ff <= 1'b0;
      end else if (taken) begin
         idx_ff <= idx_ff + IDX_W'(1);
      end
   end

   `SNFCS_ASSERT_NOW(a_push_when_free, push, buf_ready && burst.count != '0, "push into occupied buffer")
   `SNFCS_ASSERT_NOW(a_index_in_range, busy_ff, burst_ff.count != '0 && CNT_W'(idx_ff) < burst_ff.count, "read index past transfer count")
   `SNFCS_ASSERT_NEXT(a_advance, taken && !is_last, busy_ff && idx_ff == $past(idx_ff) + IDX_W'(1), "buffer did not advance after a taken transfer")

endmodule

@@ src/spi_nor_flash_command_sequencer.sv @@
// Top level of the SPI NOR flash command sequencer
// Each request enters a request register, is turned into its full list of byte transfers
// (zero to seven) in one pass and loaded into a result buffer once it is free. The buffer hands
// out one transfer per cycle while rsp_ready is high, so a request holds the buffer until all
// its transfers are accepted; one that causes none retires without touching it. The following
// request is taken as the last transfer of the previous one is accepted, so the output port,
// one byte per cycle while rsp_ready is high, sets the sustained rate. rsp_last marks the final
// transfer of each request; status_slot bytes must be answered with a status-reply request.
module spi_nor_flash_command_sequencer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_type,
   input  logic [23:0] req_address,
   input  logic [15:0] req_length,
   input  logic [7:0]  req_data_byte,
   input  logic [7:0]  req_status_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_frame_start,
   output logic        rsp_frame_end,
   output logic        rsp_read_slot,
   output logic        rsp_status_slot,
   output logic        rsp_wp_pin,
   output logic        rsp_last
);
   import snfcs_pkg::*;

   burst_type burst;
   logic      push;
   logic      buf_ready;

   snfcs_core u_core (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_address     (req_address),
      .req_length      (req_length),
      .req_data_byte   (req_data_byte),
      .req_status_byte (req_status_byte),
      .buf_ready       (buf_ready),
      .push            (push),
      .burst           (burst)
   );

   snfcs_outbuf u_outbuf (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .burst           (burst),
      .buf_ready       (buf_ready),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_tx_byte     (rsp_tx_byte),
      .rsp_frame_start (rsp_frame_start),
      .rsp_frame_end   (rsp_frame_end),
      .rsp_read_slot   (rsp_read_slot),
      .rsp_status_slot (rsp_status_slot),
      .rsp_wp_pin      (rsp_wp_pin),
      .rsp_last        (rsp_last)
   );

endmodule
